>>> src/resp_request_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// RESP request parser assertion macros
// Shorthand for clocked implication checks used by the parser.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_PARSER_UNIT_ASSERT_SVH
`define RESP_REQUEST_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define RRP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define RRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rrp_pkg.sv
// ----------------------------------------------------------------------------
// RESP request parser package
// Widths, character codes, phase/event/error encodings and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrp_pkg;

    localparam int CNT_BITS = 32;
    localparam int LEN_BITS = 32;
    localparam int ACC_W    = ((CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS) + 1;
    localparam int VAL_W    = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [ACC_W-1:0] CNT_MAX = ACC_W'({CNT_BITS{1'b1}});
    localparam logic [ACC_W-1:0] LEN_MAX = ACC_W'({LEN_BITS{1'b1}});

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [1:0] REG_MAX_COUNT  = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
    localparam logic [1:0] REG_LOWERCASE  = 2'd2;

    localparam logic [31:0] MAX_COUNT_RST  = 32'd1048576;
    localparam logic [31:0] MAX_LENGTH_RST = 32'd536870912;

    typedef enum logic [3:0] {
        PH_STAR       = 4'd0,
        PH_CNT_FIRST  = 4'd1,
        PH_CNT_DIGITS = 4'd2,
        PH_CNT_LF     = 4'd3,
        PH_DOLLAR     = 4'd4,
        PH_LEN_FIRST  = 4'd5,
        PH_LEN_DIGITS = 4'd6,
        PH_LEN_LF     = 4'd7,
        PH_PAYLOAD    = 4'd8,
        PH_PAY_CR     = 4'd9,
        PH_PAY_LF     = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        EV_ARRAY  = 3'd0,
        EV_BULK   = 3'd1,
        EV_BYTE   = 3'd2,
        EV_NULL   = 3'd3,
        EV_STATUS = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_EXP_ARRAY   = 3'd1,
        ERR_BAD_INT     = 3'd2,
        ERR_NO_CRLF     = 3'd3,
        ERR_ARRAY_SIZE  = 3'd4,
        ERR_EXP_BULK    = 3'd5,
        ERR_BULK_LENGTH = 3'd6
    } err_t;

    typedef struct packed {
        event_t           ev;
        logic [VAL_W-1:0] length_value;
        logic [7:0]       payload_byte;
        logic [VAL_W-1:0] element_index;
        logic             request_done;
        err_t             err_code;
    } result_t;

endpackage

>>> src/rrp_byte_if.sv
// ----------------------------------------------------------------------------
// RESP request parser byte channel
// Valid/ready channel carrying one raw stream byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> src/rrp_result_if.sv
// ----------------------------------------------------------------------------
// RESP request parser result channel
// Valid/ready channel carrying one parse event per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrp_result_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                event_res;
    logic [rrp_pkg::VAL_W-1:0] length_value;
    logic [7:0]                payload_byte;
    logic [rrp_pkg::VAL_W-1:0] element_index;
    logic                      request_done;
    logic [2:0]                err_code;

    modport source (output valid, output event_res, output length_value,
                    output payload_byte, output element_index,
                    output request_done, output err_code, input ready);
    modport sink   (input valid, input event_res, input length_value,
                    input payload_byte, input element_index,
                    input request_done, input err_code, output ready);
endinterface

>>> src/resp_request_parser_unit.sv
// ----------------------------------------------------------------------------
// RESP request parser
// Byte-serial parser for RESP2 request arrays with count/length limits.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  --------+--------+-------------------------------------------------------
//  req     | sink   | data_byte
//  res     | source | event_res, length_value, payload_byte, element_index,
//          |        | request_done, err_code
//  apb     | slave  | max_array_count, max_bulk_length, lowercase_command
//
//  One byte per clock while req.ready is high: each transfer updates the parse
//  state and loads at most one event into the result register.
//  The event appears on res in the cycle after its byte is taken.
//  req.ready drops only while the result register is full and res stalls.
//  rst_n clears parse state and the result valid, and returns the limit
//  registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "resp_request_parser_unit_assert.svh"

module resp_request_parser_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    rrp_byte_if.sink                     req,
    rrp_result_if.source                 res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrp_pkg::ADDR_W-1:0]   paddr,
    input  logic [rrp_pkg::DATA_W-1:0]   pwdata,
    output logic [rrp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int ACC_W = rrp_pkg::ACC_W;
    localparam int VAL_W = rrp_pkg::VAL_W;

    // configuration
    logic [31:0] max_cnt_reg;
    logic [31:0] max_len_reg;
    logic        lower_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // parse state
    rrp_pkg::phase_t    phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               seen_reg, seen_next;
    logic [VAL_W-1:0]   left_reg, left_next;
    logic [VAL_W-1:0]   elem_reg, elem_next;
    logic [VAL_W-1:0]   pay_reg, pay_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    rrp_pkg::result_t   res_reg, res_next;

    logic               accept;
    logic               emit;
    rrp_pkg::err_t      fail_code;
    logic               fail;

    // number datapath
    logic               is_digit;
    logic [3:0]         digit;
    logic [ACC_W-1:0]   num_max;
    logic [ACC_W+3:0]   acc_ext;
    logic [ACC_W+3:0]   prod;
    logic [ACC_W-1:0]   acc_digit;
    logic [7:0]         lower_byte;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            rrp_pkg::REG_MAX_COUNT:  prdata = max_cnt_reg;
            rrp_pkg::REG_MAX_LENGTH: prdata = max_len_reg;
            rrp_pkg::REG_LOWERCASE:  prdata = {31'd0, lower_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cnt_reg <= rrp_pkg::MAX_COUNT_RST;
            max_len_reg <= rrp_pkg::MAX_LENGTH_RST;
            lower_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                rrp_pkg::REG_MAX_COUNT:  max_cnt_reg <= pwdata;
                rrp_pkg::REG_MAX_LENGTH: max_len_reg <= pwdata;
                rrp_pkg::REG_LOWERCASE:  lower_reg   <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Number accumulation: acc*10 + digit, saturating one past the bound
    // ------------------------------------------------------------------
    assign is_digit = (req.data_byte >= rrp_pkg::CH_ZERO) &&
                      (req.data_byte <= rrp_pkg::CH_NINE);
    assign digit    = 4'(req.data_byte - rrp_pkg::CH_ZERO);
    assign num_max  = ((phase_reg == rrp_pkg::PH_CNT_FIRST) ||
                       (phase_reg == rrp_pkg::PH_CNT_DIGITS)) ?
                      rrp_pkg::CNT_MAX : rrp_pkg::LEN_MAX;
    assign acc_ext  = (ACC_W+4)'(acc_reg);
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + (ACC_W+4)'(digit);

    always_comb
    begin
        if (acc_reg > num_max)
            acc_digit = acc_reg;
        else if (prod > (ACC_W+4)'(num_max))
            acc_digit = num_max + ACC_W'(1);
        else
            acc_digit = prod[ACC_W-1:0];
    end

    // lowercase letters of the command name
    assign lower_byte = ((elem_reg == '0) && lower_reg &&
                         (req.data_byte >= rrp_pkg::CH_UPPER_A) &&
                         (req.data_byte <= rrp_pkg::CH_UPPER_Z)) ?
                        req.data_byte + rrp_pkg::CASE_OFFSET : req.data_byte;

    // ------------------------------------------------------------------
    // Parse step
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        elem_next  = elem_reg;
        pay_next   = pay_reg;
        emit       = 1'b0;
        fail_code  = rrp_pkg::ERR_NONE;
        res_next   = '{ev: rrp_pkg::EV_STATUS, length_value: '0, payload_byte: '0,
                       element_index: elem_reg, request_done: 1'b0,
                       err_code: rrp_pkg::ERR_NONE};

        case (phase_reg)
            rrp_pkg::PH_CNT_FIRST, rrp_pkg::PH_CNT_DIGITS,
            rrp_pkg::PH_LEN_FIRST, rrp_pkg::PH_LEN_DIGITS:
            begin
                if (((phase_reg == rrp_pkg::PH_CNT_FIRST) ||
                     (phase_reg == rrp_pkg::PH_LEN_FIRST)) &&
                    (req.data_byte == rrp_pkg::CH_MINUS))
                begin
                    neg_next   = 1'b1;
                    phase_next = (phase_reg == rrp_pkg::PH_CNT_FIRST) ?
                                 rrp_pkg::PH_CNT_DIGITS : rrp_pkg::PH_LEN_DIGITS;
                end
                else if (is_digit)
                begin
                    seen_next  = 1'b1;
                    acc_next   = acc_digit;
                    phase_next = ((phase_reg == rrp_pkg::PH_CNT_FIRST) ||
                                  (phase_reg == rrp_pkg::PH_CNT_DIGITS)) ?
                                 rrp_pkg::PH_CNT_DIGITS : rrp_pkg::PH_LEN_DIGITS;
                end
                else if (!seen_reg)
                    fail_code = rrp_pkg::ERR_BAD_INT;
                else if (req.data_byte != rrp_pkg::CH_CR)
                    fail_code = rrp_pkg::ERR_NO_CRLF;
                else
                    phase_next = ((phase_reg == rrp_pkg::PH_CNT_FIRST) ||
                                  (phase_reg == rrp_pkg::PH_CNT_DIGITS)) ?
                                 rrp_pkg::PH_CNT_LF : rrp_pkg::PH_LEN_LF;
            end

            rrp_pkg::PH_CNT_LF:
            begin
                if (req.data_byte != rrp_pkg::CH_LF)
                    fail_code = rrp_pkg::ERR_NO_CRLF;
                else if ((neg_reg && (acc_reg != '0)) ||
                         (acc_reg > ACC_W'(max_cnt_reg)))
                    fail_code = rrp_pkg::ERR_ARRAY_SIZE;
                else
                begin
                    emit                   = 1'b1;
                    res_next.ev            = rrp_pkg::EV_ARRAY;
                    res_next.element_index = '0;
                    if (acc_reg == '0)
                    begin
                        // empty array ends the request here
                        res_next.request_done = 1'b1;
                        phase_next = rrp_pkg::PH_STAR;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        seen_next  = 1'b0;
                        left_next  = '0;
                        elem_next  = '0;
                        pay_next   = '0;
                    end
                    else
                    begin
                        res_next.length_value = acc_reg[VAL_W-1:0];
                        left_next  = acc_reg[VAL_W-1:0];
                        elem_next  = '0;
                        phase_next = rrp_pkg::PH_DOLLAR;
                    end
                end
            end

            rrp_pkg::PH_DOLLAR:
            begin
                if (req.data_byte != rrp_pkg::CH_DOLLAR)
                    fail_code = rrp_pkg::ERR_EXP_BULK;
                else
                begin
                    phase_next = rrp_pkg::PH_LEN_FIRST;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                end
            end

            rrp_pkg::PH_LEN_LF:
            begin
                if (req.data_byte != rrp_pkg::CH_LF)
                    fail_code = rrp_pkg::ERR_NO_CRLF;
                else if (neg_reg && (acc_reg == ACC_W'(1)))
                begin
                    emit        = 1'b1;
                    res_next.ev = rrp_pkg::EV_NULL;
                    if (left_reg <= VAL_W'(1))
                    begin
                        res_next.request_done = 1'b1;
                        phase_next = rrp_pkg::PH_STAR;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        seen_next  = 1'b0;
                        left_next  = '0;
                        elem_next  = '0;
                        pay_next   = '0;
                    end
                    else
                    begin
                        left_next  = left_reg - VAL_W'(1);
                        elem_next  = elem_reg + VAL_W'(1);
                        phase_next = rrp_pkg::PH_DOLLAR;
                    end
                end
                else if ((neg_reg && (acc_reg != '0)) ||
                         (acc_reg > ACC_W'(max_len_reg)))
                    fail_code = rrp_pkg::ERR_BULK_LENGTH;
                else
                begin
                    emit                  = 1'b1;
                    res_next.ev           = rrp_pkg::EV_BULK;
                    res_next.length_value = acc_reg[VAL_W-1:0];
                    pay_next   = acc_reg[VAL_W-1:0];
                    phase_next = (acc_reg == '0) ? rrp_pkg::PH_PAY_CR : rrp_pkg::PH_PAYLOAD;
                end
            end

            rrp_pkg::PH_PAYLOAD:
            begin
                emit                  = 1'b1;
                res_next.ev           = rrp_pkg::EV_BYTE;
                res_next.payload_byte = lower_byte;
                pay_next = pay_reg - VAL_W'(1);
                if (pay_reg == VAL_W'(1))
                    phase_next = rrp_pkg::PH_PAY_CR;
            end

            rrp_pkg::PH_PAY_CR:
            begin
                if (req.data_byte != rrp_pkg::CH_CR)
                    fail_code = rrp_pkg::ERR_NO_CRLF;
                else
                    phase_next = rrp_pkg::PH_PAY_LF;
            end

            rrp_pkg::PH_PAY_LF:
            begin
                if (req.data_byte != rrp_pkg::CH_LF)
                    fail_code = rrp_pkg::ERR_NO_CRLF;
                else if (left_reg <= VAL_W'(1))
                begin
                    // closing CRLF of the last element completes the request
                    emit                  = 1'b1;
                    res_next.request_done = 1'b1;
                    phase_next = rrp_pkg::PH_STAR;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                    left_next  = '0;
                    elem_next  = '0;
                    pay_next   = '0;
                end
                else
                begin
                    left_next  = left_reg - VAL_W'(1);
                    elem_next  = elem_reg + VAL_W'(1);
                    phase_next = rrp_pkg::PH_DOLLAR;
                end
            end

            default:
            begin
                // expect '*'; unused phase codes land here too
                if (req.data_byte != rrp_pkg::CH_STAR)
                    fail_code = rrp_pkg::ERR_EXP_ARRAY;
                else
                begin
                    phase_next = rrp_pkg::PH_CNT_FIRST;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                    left_next  = '0;
                    elem_next  = '0;
                    pay_next   = '0;
                end
            end
        endcase

        // any error: report it and drop back to expecting '*'
        if (fail_code != rrp_pkg::ERR_NONE)
        begin
            emit     = 1'b1;
            res_next = '{ev: rrp_pkg::EV_STATUS, length_value: '0, payload_byte: '0,
                         element_index: elem_reg, request_done: 1'b0,
                         err_code: fail_code};
            phase_next = rrp_pkg::PH_STAR;
            acc_next   = '0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            left_next  = '0;
            elem_next  = '0;
            pay_next   = '0;
        end
    end

    assign fail = (fail_code != rrp_pkg::ERR_NONE);

    always_comb
    begin
        if (accept)
            out_valid_next = emit;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rrp_pkg::PH_STAR;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            left_reg      <= '0;
            elem_reg      <= '0;
            pay_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                left_reg  <= left_next;
                elem_reg  <= elem_next;
                pay_reg   <= pay_next;
            end
        end
    end

    // hold the result until its transfer completes
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.event_res     = res_reg.ev;
    assign res.length_value  = res_reg.length_value;
    assign res.payload_byte  = res_reg.payload_byte;
    assign res.element_index = res_reg.element_index;
    assign res.request_done  = res_reg.request_done;
    assign res.err_code      = res_reg.err_code;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RRP_ASSERT_IMPLIES(a_done_no_error, clk, rst_n,
        out_valid_reg && res_reg.request_done, res_reg.err_code == rrp_pkg::ERR_NONE,
        "completed request carries an error code")
    `RRP_ASSERT_NEXT(a_error_clears, clk, rst_n, accept && fail,
        (phase_reg == rrp_pkg::PH_STAR) && (left_reg == '0) && (elem_reg == '0),
        "parse state not cleared after an error")
    `RRP_ASSERT_IMPLIES(a_payload_left, clk, rst_n, phase_reg == rrp_pkg::PH_PAYLOAD,
        pay_reg != '0, "payload phase with no bytes left")

endmodule
